// ----- rtl/core/ehtq_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_pkg
// Shared types and codes for the expiry heap timer queue.
// ============================================================================
package ehtq_pkg;

    // Fixed field widths.
    localparam int TimeW   = 24;
    localparam int ExpW    = 25;
    localparam int HandleW = 6;
    localparam int ConnW   = 16;
    localparam int KeyW    = ExpW + HandleW;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_SWEEP  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes.
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_BAD       = 3'd3;
    localparam logic [2:0] ST_CLOSED    = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_UP_RD,
        S_UP_CMP,
        S_CAN,
        S_SW_RD,
        S_SW_CHK,
        S_POP_RD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_SW_POST,
        S_DONE
    } st_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic idle;
        logic add_do;
        logic up_rd;
        logic up_cmp;
        logic can_do;
        logic rd_top;
        logic chk;
        logic pop_load;
        logic dn_rdl;
        logic dn_rdr;
        logic dn_cmp;
        logic post;
        logic done;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       in_fire;
        logic [1:0] req;
        logic       full;
        logic       zero_i;
        logic       up_stop;
        logic       count_zero;
        logic       count_one;
        logic       top_stop;
        logic       l_out;
        logic       key_min;
        logic       post_stall;
        logic       out_free;
    } sts_t;

endpackage

// ----- rtl/core/ehtq_req_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_req_if
// Request channel: valid/ready handshake with the request payload.
// ============================================================================
interface ehtq_req_if import ehtq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [TimeW-1:0]   now_ms;
    logic [TimeW-1:0]   timeout_ms;
    logic [ConnW-1:0]   conn_id;
    logic [HandleW-1:0] timer_handle;

    modport source (output valid, req_type, now_ms, timeout_ms, conn_id, timer_handle,
                    input ready);
    modport sink (input valid, req_type, now_ms, timeout_ms, conn_id, timer_handle,
                  output ready);
endinterface

// ----- rtl/core/ehtq_rsp_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ============================================================================
interface ehtq_rsp_if import ehtq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [HandleW-1:0] result_handle;
    logic [ConnW-1:0]   closed_conn;
    logic               last;

    modport source (output valid, status, result_handle, closed_conn, last, input ready);
    modport sink (input valid, status, result_handle, closed_conn, last, output ready);
endinterface

// ----- rtl/core/ehtq_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ehtq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- rtl/core/ehtq_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_ctrl
// Controller state machine: sequences add, cancel and sweep operations.
// ============================================================================
module ehtq_ctrl import ehtq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    st_t state_reg;
    st_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_fire)
                begin
                    unique case (req_t'(sts.req))
                        REQ_ADD:    state_next = S_ADD;
                        REQ_CANCEL: state_next = S_CAN;
                        REQ_SWEEP:  state_next = S_SW_RD;
                        REQ_NONE:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_do = 1'b1;
                state_next = sts.full ? S_DONE : S_UP_RD;
            end
            S_UP_RD:
            begin
                cmd.up_rd  = 1'b1;
                state_next = sts.zero_i ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmd.up_cmp = 1'b1;
                state_next = sts.up_stop ? S_DONE : S_UP_RD;
            end
            S_CAN:
            begin
                cmd.can_do = 1'b1;
                state_next = S_DONE;
            end
            S_SW_RD:
            begin
                cmd.rd_top = 1'b1;
                state_next = sts.count_zero ? S_DONE : S_SW_CHK;
            end
            S_SW_CHK:
            begin
                cmd.chk = 1'b1;
                priority if (sts.top_stop)
                begin
                    state_next = S_DONE;
                end
                else if (sts.count_one)
                begin
                    state_next = S_SW_POST;
                end
                else
                begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                cmd.dn_rdl = 1'b1;
                state_next = sts.l_out ? S_SW_POST : S_DN_RDR;
            end
            S_DN_RDR:
            begin
                cmd.dn_rdr = 1'b1;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.dn_cmp = 1'b1;
                state_next = sts.key_min ? S_SW_POST : S_DN_RDL;
            end
            S_SW_POST:
            begin
                cmd.post   = 1'b1;
                state_next = sts.post_stall ? S_SW_POST : S_SW_RD;
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = sts.out_free ? S_IDLE : S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ehtq_dp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ehtq_dp
// Datapath: slot flags, heap and connection memories, sift registers and
// the pending and output result registers.
// ============================================================================
module ehtq_dp import ehtq_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    ehtq_req_if.sink   req,
    ehtq_rsp_if.source rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = IW + 2;

    // Slot flags and heap fill count.
    logic [SLOTS-1:0] live_reg;
    logic [SLOTS-1:0] connf_reg;
    logic [SLOTS-1:0] del_reg;
    logic [CW-1:0]    count_reg;

    // Latched request.
    logic [TimeW-1:0]   now_reg;
    logic [TimeW-1:0]   tmo_reg;
    logic [ConnW-1:0]   cid_reg;
    logic [HandleW-1:0] th_reg;

    // Sift working registers.
    logic [KeyW-1:0] key_reg;
    logic [IW-1:0]   idx_reg;
    logic [KeyW-1:0] lv_reg;
    logic [IW-1:0]   pop_h_reg;
    logic            pop_conn_reg;

    // Pending result and output register.
    logic               pend_valid_reg;
    logic [2:0]         pend_status_reg;
    logic [HandleW-1:0] pend_handle_reg;
    logic [ConnW-1:0]   pend_conn_reg;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [HandleW-1:0] out_handle_reg;
    logic [ConnW-1:0]   out_conn_reg;
    logic               out_last_reg;

    // Memory ports.
    logic             heap_we;
    logic [IW-1:0]    heap_waddr;
    logic [KeyW-1:0]  heap_wdata;
    logic             heap_re;
    logic [IW-1:0]    heap_raddr;
    logic [KeyW-1:0]  heap_q;
    logic             conn_we;
    logic             conn_re;
    logic [ConnW-1:0] conn_q;

    // Combinational helpers.
    logic            in_fire;
    logic            out_free;
    logic            free_any;
    logic [IW-1:0]   free_idx;
    logic            full;
    logic [ExpW-1:0] exp_new;
    logic [IW-1:0]   parent;
    logic            up_stop;
    logic [IW-1:0]   top_h;
    logic            top_stop;
    logic [LW-1:0]   l_idx;
    logic [LW-1:0]   r_idx;
    logic            l_out;
    logic            r_in;
    logic            pick_r;
    logic [KeyW-1:0] mval;
    logic [IW-1:0]   midx;
    logic            key_min;
    logic            can_ok;
    logic            post_stall;
    logic            load_pend_out;
    logic            load_done_out;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = cmd.idle;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Lowest slot that is not live.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!live_reg[s])
            begin
                free_any = 1'b1;
                free_idx = IW'(s);
            end
        end
    end

    assign full    = !free_any || (count_reg == CW'(SLOTS));
    assign exp_new = {1'b0, now_reg} + {1'b0, tmo_reg};

    // Sift-up compare against the parent.
    assign parent  = IW'((idx_reg - IW'(1)) >> 1);
    assign up_stop = heap_q < key_reg;

    // Top of heap check for the sweep.
    assign top_h    = heap_q[IW-1:0];
    assign top_stop = !del_reg[top_h] && ({1'b0, now_reg} < heap_q[KeyW-1:HandleW]);

    // Sift-down children and smallest candidate.
    assign l_idx   = {1'b0, idx_reg, 1'b1};
    assign r_idx   = l_idx + LW'(1);
    assign l_out   = l_idx >= LW'(count_reg);
    assign r_in    = r_idx < LW'(count_reg);
    assign pick_r  = r_in && (heap_q < lv_reg);
    assign mval    = pick_r ? heap_q : lv_reg;
    assign midx    = pick_r ? r_idx[IW-1:0] : l_idx[IW-1:0];
    assign key_min = key_reg < mval;

    assign can_ok = ({1'b0, th_reg} < (HandleW + 1)'(SLOTS)) &&
                    live_reg[th_reg[IW-1:0]] && !del_reg[th_reg[IW-1:0]];

    assign post_stall    = pop_conn_reg && pend_valid_reg && !out_free;
    assign load_pend_out = cmd.post && pop_conn_reg && pend_valid_reg && out_free;
    assign load_done_out = cmd.done && out_free;

    // Heap memory port control.
    always_comb
    begin
        heap_re    = 1'b0;
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = key_reg;
        priority if (cmd.chk)
        begin
            heap_re    = !top_stop && (count_reg != CW'(1));
            heap_raddr = IW'(count_reg - CW'(1));
        end
        else if (cmd.dn_rdl)
        begin
            heap_re    = !l_out;
            heap_raddr = l_idx[IW-1:0];
            heap_we    = l_out;
        end
        else if (cmd.dn_rdr)
        begin
            heap_re    = r_in;
            heap_raddr = r_idx[IW-1:0];
        end
        else if (cmd.dn_cmp)
        begin
            heap_we    = 1'b1;
            heap_wdata = key_min ? key_reg : mval;
        end
        else if (cmd.up_rd)
        begin
            heap_re    = (idx_reg != '0);
            heap_raddr = parent;
            heap_we    = (idx_reg == '0);
        end
        else if (cmd.up_cmp)
        begin
            heap_we    = 1'b1;
            heap_wdata = up_stop ? key_reg : heap_q;
        end
        else
        begin
            heap_re = cmd.rd_top;
        end
    end

    assign conn_we = cmd.add_do && !full;
    assign conn_re = cmd.chk && !top_stop;

    ehtq_ram #(.WIDTH(KeyW), .DEPTH(SLOTS)) u_heap_ram (
        .clk     (clk),
        .wr_en   (heap_we),
        .wr_addr (heap_waddr),
        .wr_data (heap_wdata),
        .rd_en   (heap_re),
        .rd_addr (heap_raddr),
        .rd_data (heap_q)
    );

    ehtq_ram #(.WIDTH(ConnW), .DEPTH(SLOTS)) u_conn_ram (
        .clk     (clk),
        .wr_en   (conn_we),
        .wr_addr (free_idx),
        .wr_data (cid_reg),
        .rd_en   (conn_re),
        .rd_addr (top_h),
        .rd_data (conn_q)
    );

    // Control state: flags, count, pending and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            connf_reg      <= '0;
            del_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.add_do)
            begin
                pend_valid_reg <= 1'b1;
                if (!full)
                begin
                    live_reg[free_idx]  <= 1'b1;
                    connf_reg[free_idx] <= 1'b1;
                    del_reg[free_idx]   <= 1'b0;
                    count_reg           <= count_reg + CW'(1);
                end
            end
            if (cmd.can_do)
            begin
                pend_valid_reg <= 1'b1;
                if (can_ok)
                begin
                    connf_reg[th_reg[IW-1:0]] <= 1'b0;
                    del_reg[th_reg[IW-1:0]]   <= 1'b1;
                end
            end
            if (cmd.chk && !top_stop)
            begin
                live_reg[top_h]  <= 1'b0;
                connf_reg[top_h] <= 1'b0;
                del_reg[top_h]   <= 1'b0;
                count_reg        <= count_reg - CW'(1);
            end
            if (cmd.post && pop_conn_reg && !post_stall)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (load_done_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (load_pend_out || load_done_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= req.now_ms;
            tmo_reg <= req.timeout_ms;
            cid_reg <= req.conn_id;
            th_reg  <= req.timer_handle;
        end
        if (cmd.add_do)
        begin
            key_reg         <= {exp_new, HandleW'(free_idx)};
            idx_reg         <= count_reg[IW-1:0];
            pend_status_reg <= full ? ST_FULL : ST_ADDED;
            pend_handle_reg <= full ? '0 : HandleW'(free_idx);
            pend_conn_reg   <= '0;
        end
        if (cmd.up_cmp && !up_stop)
        begin
            idx_reg <= parent;
        end
        if (cmd.can_do)
        begin
            pend_status_reg <= can_ok ? ST_CANCELLED : ST_BAD;
            pend_handle_reg <= th_reg;
            pend_conn_reg   <= '0;
        end
        if (cmd.chk)
        begin
            pop_h_reg    <= top_h;
            pop_conn_reg <= connf_reg[top_h];
        end
        if (cmd.pop_load)
        begin
            key_reg <= heap_q;
            idx_reg <= '0;
        end
        if (cmd.dn_rdr)
        begin
            lv_reg <= heap_q;
        end
        if (cmd.dn_cmp && !key_min)
        begin
            idx_reg <= midx;
        end
        if (cmd.post && pop_conn_reg && !post_stall)
        begin
            pend_status_reg <= ST_CLOSED;
            pend_handle_reg <= HandleW'(pop_h_reg);
            pend_conn_reg   <= conn_q;
        end
        if (load_pend_out)
        begin
            out_status_reg <= pend_status_reg;
            out_handle_reg <= pend_handle_reg;
            out_conn_reg   <= pend_conn_reg;
            out_last_reg   <= 1'b0;
        end
        else if (load_done_out)
        begin
            out_status_reg <= pend_valid_reg ? pend_status_reg : ST_NONE;
            out_handle_reg <= pend_valid_reg ? pend_handle_reg : '0;
            out_conn_reg   <= pend_valid_reg ? pend_conn_reg : '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_handle = out_handle_reg;
    assign rsp.closed_conn   = out_conn_reg;
    assign rsp.last          = out_last_reg;

    // Status to the controller.
    always_comb
    begin
        sts.in_fire    = in_fire;
        sts.req        = req.req_type;
        sts.full       = full;
        sts.zero_i     = (idx_reg == '0);
        sts.up_stop    = up_stop;
        sts.count_zero = (count_reg == '0);
        sts.count_one  = (count_reg == CW'(1));
        sts.top_stop   = top_stop;
        sts.l_out      = l_out;
        sts.key_min    = key_min;
        sts.post_stall = post_stall;
        sts.out_free   = out_free;
    end

endmodule

// ----- rtl/core/expiry_heap_timer_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// expiry_heap_timer_queue
// Connection timeout queue: min-heap of expiry times with lazy deletion.
// ============================================================================
// Usage: requests enter on the req channel (add, cancel, sweep) and results
// leave on the rsp channel; every transaction on either side is a valid and
// ready handshake. The block works on one request at a time: req.ready is
// high only while it is idle. Each request gives one or more results, the
// final one marked by last. Request code 3 is taken and gives no result.
// An add writes the new timer at the end of the heap and sifts it up level
// by level, with no sift when the table is full. A sweep checks the heap top
// and pops each expired or cancelled timer; the last entry then moves to the
// top and sifts down, compared with its children level by level. The heap
// memory has a single read port.
// A pending result register and an output register separate the sides; when
// the receiver stalls, a sweep holds at a close event while a result is
// still pending, until the output register is taken.
// Reset empties the queue at once: all slots free, heap count zero.
// ============================================================================
module expiry_heap_timer_queue import ehtq_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ehtq_req_if.sink   req,
    ehtq_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    ehtq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ehtq_dp #(.SLOTS(SLOTS)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

    // A real request blocks further requests until it is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.req_type != REQ_NONE) |=> !req.ready)
        else $error("request accepted while another is in progress");

    // Only a close event carries a connection.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_CLOSED) |-> rsp.closed_conn == '0)
        else $error("connection field set on a non-close result");

    // Add and cancel results are always final.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_ADDED || rsp.status == ST_FULL ||
                      rsp.status == ST_CANCELLED || rsp.status == ST_BAD) |-> rsp.last)
        else $error("single-result request not marked last");

endmodule

// ----- sim/tb_expiry_heap_timer_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_expiry_heap_timer_queue
// Self-checking bench for the expiry heap timer queue: a queue-fed driver
// and a monitor check every result against an internal heap predictor.
// ============================================================================
module tb_expiry_heap_timer_queue;
    import ehtq_pkg::*;

    localparam int NSLOT     = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 400;

    // One request as queued for the driver.
    typedef struct packed {
        req_t        kind;
        logic [23:0] now;
        logic [23:0] tmo;
        logic [15:0] conn;
        logic [5:0]  hnd;
    } timer_req_t;

    // One expected result.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  hnd;
        logic [15:0] conn;
        logic        last;
    } timer_rsp_t;

    logic clk;
    logic rst_n;

    ehtq_req_if req_ch();
    ehtq_rsp_if rsp_ch();

    expiry_heap_timer_queue #(.SLOTS(NSLOT)) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    // Predictor state: heap keys are expiry above handle.
    logic [30:0] heap_key[NSLOT];
    int          heap_len;
    logic [15:0] slot_owner[NSLOT];
    bit          slot_live[NSLOT];
    bit          slot_has_conn[NSLOT];
    bit          slot_dead[NSLOT];

    timer_req_t pending_reqs[$];
    timer_rsp_t expected_rsps[$];

    int  fail_count;
    bit  quiet_mode;
    int  src_gap;
    int  snk_stall;
    int  idle_cycles;

    // Bench time tracker kept roughly monotonic so sweeps expire timers.
    int unsigned cur_now;

    always #5 clk = ~clk;

    // Push a key and sift it up.
    task automatic heap_insert(input logic [30:0] key);
        int i;
        int p;
        logic [30:0] t;
        i = heap_len;
        heap_key[i] = key;
        heap_len++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_key[p] <= heap_key[i]) break;
            t = heap_key[p]; heap_key[p] = heap_key[i]; heap_key[i] = t;
            i = p;
        end
    endtask

    // Remove the top and sift the last entry down.
    task automatic heap_remove_top();
        int i;
        int l;
        int r;
        int m;
        logic [30:0] t;
        i = 0;
        heap_len--;
        heap_key[0] = heap_key[heap_len];
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < heap_len && heap_key[l] < heap_key[m]) m = l;
            if (r < heap_len && heap_key[r] < heap_key[m]) m = r;
            if (m == i) break;
            t = heap_key[i]; heap_key[i] = heap_key[m]; heap_key[m] = t;
            i = m;
        end
    endtask

    // Work out the results of one request and update the predicted state.
    task automatic predict_timer_req(input timer_req_t r);
        timer_rsp_t res[$];
        timer_rsp_t e;
        int s;
        int h;
        logic [24:0] expiry;
        logic [30:0] top;
        e = '0;
        case (r.kind)
            REQ_ADD: begin
                for (s = 0; s < NSLOT; s++)
                    if (!slot_live[s]) break;
                if (s >= NSLOT || heap_len >= NSLOT) begin
                    e.status = ST_FULL;
                end else begin
                    expiry = {1'b0, r.now} + {1'b0, r.tmo};
                    slot_live[s] = 1; slot_has_conn[s] = 1; slot_dead[s] = 0;
                    slot_owner[s] = r.conn;
                    heap_insert({expiry, 6'(s)});
                    e.status = ST_ADDED;
                    e.hnd = 6'(s);
                end
                res.push_back(e);
            end
            REQ_CANCEL: begin
                h = r.hnd;
                if (slot_live[h] && !slot_dead[h]) begin
                    slot_dead[h] = 1; slot_has_conn[h] = 0; slot_owner[h] = '0;
                    e.status = ST_CANCELLED;
                end else begin
                    e.status = ST_BAD;
                end
                e.hnd = r.hnd;
                res.push_back(e);
            end
            REQ_SWEEP: begin
                while (heap_len > 0) begin
                    top = heap_key[0];
                    h = top[5:0];
                    if (!slot_dead[h] && {1'b0, r.now} < top[30:6]) break;
                    heap_remove_top();
                    if (slot_has_conn[h]) begin
                        e = '0;
                        e.status = ST_CLOSED;
                        e.hnd = 6'(h);
                        e.conn = slot_owner[h];
                        res.push_back(e);
                    end
                    slot_live[h] = 0; slot_has_conn[h] = 0; slot_dead[h] = 0;
                    slot_owner[h] = '0;
                end
                if (res.size() == 0) begin
                    e = '0;
                    e.status = ST_NONE;
                    res.push_back(e);
                end
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_rsps.push_back(res[i]);
    endtask

    function automatic timer_req_t make_req(req_t k, int unsigned now, int unsigned tmo,
                                            int unsigned conn, int unsigned hnd);
        timer_req_t r;
        r.kind = k;
        r.now  = 24'(now);
        r.tmo  = 24'(tmo);
        r.conn = 16'(conn);
        r.hnd  = 6'(hnd);
        return r;
    endfunction

    // Driver: presents queued requests and predicts each accepted one.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= REQ_NONE;
            req_ch.now_ms       <= '0;
            req_ch.timeout_ms   <= '0;
            req_ch.conn_id      <= '0;
            req_ch.timer_handle <= '0;
            src_gap             <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_timer_req(pending_reqs.pop_front());
            end
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(1, 15);
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_ch.valid        <= 1'b1;
                    req_ch.req_type     <= pending_reqs[0].kind;
                    req_ch.now_ms       <= pending_reqs[0].now;
                    req_ch.timeout_ms   <= pending_reqs[0].tmo;
                    req_ch.conn_id      <= pending_reqs[0].conn;
                    req_ch.timer_handle <= pending_reqs[0].hnd;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        timer_rsp_t e;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            snk_stall    <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result: status %0d handle %0d",
                           rsp_ch.status, rsp_ch.result_handle);
                    fail_count++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.result_handle !== e.hnd) begin
                        $error("result_handle: expected %0d actual %0d",
                               e.hnd, rsp_ch.result_handle);
                        fail_count++;
                    end
                    if (rsp_ch.closed_conn !== e.conn) begin
                        $error("closed_conn: expected %0d actual %0d",
                               e.conn, rsp_ch.closed_conn);
                        fail_count++;
                    end
                    if (rsp_ch.last !== e.last) begin
                        $error("last: expected %0d actual %0d", e.last, rsp_ch.last);
                        fail_count++;
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall    <= snk_stall - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                snk_stall    <= $urandom_range(1, 15);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles with no transaction on either side.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("expiry_heap_timer_queue verification failed");
                $finish;
            end
        end
    end

    // Builds one random request, mostly well-formed with advancing time.
    function automatic timer_req_t rand_req();
        int unsigned pick;
        int unsigned hnd;
        pick = $urandom_range(0, 99);
        cur_now = cur_now + $urandom_range(0, 300);
        if (cur_now > 9999999) cur_now = $urandom_range(0, 1000);
        if (pick < 50) begin
            return make_req(REQ_ADD, cur_now, ($urandom_range(0, 19) == 0) ?
                            $urandom : $urandom_range(0, 3000), $urandom, 0);
        end else if (pick < 72) begin
            hnd = $urandom_range(0, 63);
            return make_req(REQ_CANCEL, $urandom, $urandom, $urandom, hnd);
        end else if (pick < 97) begin
            return make_req(REQ_SWEEP, cur_now, $urandom, $urandom, $urandom);
        end else if (pick < 99) begin
            return make_req(REQ_SWEEP, $urandom_range(0, 9999999), $urandom, $urandom, 0);
        end
        return make_req(REQ_NONE, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Stimulus and end of run.
    initial begin
        int wait_cyc;
        clk = 1'b0;
        rst_n = 1'b0;
        quiet_mode = 0;
        cur_now = 1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty sweep, bad handles, field extremes, equal expiries.
        pending_reqs.push_back(make_req(REQ_SWEEP, 24'hFFFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 0, 0, 63));
        pending_reqs.push_back(make_req(REQ_ADD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(REQ_ADD, 0, 0, 0, 63));
        pending_reqs.push_back(make_req(REQ_ADD, 100, 50, 16'hAAAA, 0));
        pending_reqs.push_back(make_req(REQ_ADD, 50, 100, 16'h5555, 0));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 0, 0, 2));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 0, 0, 2));
        pending_reqs.push_back(make_req(REQ_NONE, 24'hABCDEF, 24'h123456, 16'h1234, 21));
        pending_reqs.push_back(make_req(REQ_SWEEP, 149, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_SWEEP, 150, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_SWEEP, 24'hFFFFFF, 0, 0, 0));
        // Fill the table to full, then drain it in one sweep.
        for (int i = 0; i < 65; i++)
            pending_reqs.push_back(make_req(REQ_ADD, 500, i % 4, i * 997, 0));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 0, 0, 7));
        pending_reqs.push_back(make_req(REQ_SWEEP, 24'hFFFFFF, 0, 0, 0));

        for (int i = 0; i < 330; i++) begin
            if (i == 260) begin
                wait (pending_reqs.size() == 0);
                quiet_mode = 1;
            end
            pending_reqs.push_back(rand_req());
        end
        pending_reqs.push_back(make_req(REQ_SWEEP, 24'hFFFFFF, 0, 0, 0));

        wait (pending_reqs.size() == 0);
        wait_cyc = 0;
        while (expected_rsps.size() > 0 && wait_cyc < 200000) begin
            @(posedge clk);
            wait_cyc++;
        end
        if (expected_rsps.size() > 0) begin
            $display("expiry_heap_timer_queue verification failed");
            $finish;
        end else begin
            repeat (DRAIN_CYC) @(posedge clk);
            if (fail_count == 0 && expected_rsps.size() == 0)
                $display("expiry_heap_timer_queue verification clean");
            else
                $display("expiry_heap_timer_queue verification failed");
            $finish;
        end
    end

endmodule

// ----- expiry_heap_timer_queue.f -----
rtl/core/ehtq_pkg.sv
rtl/core/ehtq_req_if.sv
rtl/core/ehtq_rsp_if.sv
rtl/core/ehtq_ram.sv
rtl/core/ehtq_ctrl.sv
rtl/core/ehtq_dp.sv
rtl/core/expiry_heap_timer_queue.sv
sim/tb_expiry_heap_timer_queue.sv
